// File: rtl/windowed_reorder_buffer_assert.svh
`ifndef WINDOWED_REORDER_BUFFER_ASSERT_SVH
`define WINDOWED_REORDER_BUFFER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define WRB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("windowed_reorder_buffer: assertion failed");

// Checks that a consequence holds in the same cycle as its cause.
`define WRB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_reorder_buffer: assertion failed");

// Checks that a consequence holds in the cycle after its cause.
`define WRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_reorder_buffer: assertion failed");

`endif

// File: rtl/wrb_pkg.sv
package wrb_pkg;

    localparam int RING_DEPTH_DEF   = 8;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic [1:0] REQ_ADMIT    = 2'd0;
    localparam logic [1:0] REQ_COMPLETE = 2'd1;
    localparam logic [1:0] REQ_ABORT    = 2'd2;

    localparam logic [3:0] ST_GRANT         = 4'd0;
    localparam logic [3:0] ST_WAIT          = 4'd1;
    localparam logic [3:0] ST_REFUSED       = 4'd2;
    localparam logic [3:0] ST_STORED        = 4'd3;
    localparam logic [3:0] ST_PUSH_ABORTED  = 4'd4;
    localparam logic [3:0] ST_OUT_OF_WINDOW = 4'd5;
    localparam logic [3:0] ST_DUPLICATE     = 4'd6;
    localparam logic [3:0] ST_DELIVERED     = 4'd7;
    localparam logic [3:0] ST_ABORT_DONE    = 4'd8;

    localparam logic ADDR_TOTAL_FRAMES = 1'b0;
    localparam logic ADDR_WINDOW_SIZE  = 1'b1;

endpackage

// File: rtl/windowed_reorder_buffer.sv
// In-order reassembly buffer with a sliding admission window. Each input item
// is an admission request, a completion or an abort, and gives one result. An
// item of an unknown request type gives none. A completion that fills the slot
// of the next expected index also releases every consecutive ready entry, one
// delivered result each, and the last result of an item carries the last mark.
// Payload and ok flag of a completed entry live in a ring memory with a
// registered read; the valid bits are flip-flops. An admission, an abort, an
// unknown request or a completion that releases no entry is accepted, then
// decided. A stored completion that releases entries then passes a read step
// and delivers one entry at a time, since the first memory read is issued
// after the write and each later read is issued ahead while the previous
// entry goes out. A stall on the result side holds decide and deliver. The
// input is taken while a result still waits in the output register.
`include "windowed_reorder_buffer_assert.svh"

module windowed_reorder_buffer #(
    parameter int RING_DEPTH   = wrb_pkg::RING_DEPTH_DEF,
    parameter int PAYLOAD_BITS = wrb_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] item_index,
    input  logic [31:0] payload,
    input  logic        item_ok,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [31:0] out_index,
    output logic [31:0] out_payload,
    output logic        out_ok,
    output logic        all_done,
    output logic        last
);

    localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int WIN_W   = $clog2(RING_DEPTH + 1);
    localparam int STORE_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_DECIDE  = 2'd1;
    localparam logic [1:0] S_READ    = 2'd2;
    localparam logic [1:0] S_DELIVER = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [31:0]           total_frames_reg;
    logic [6:0]            window_size_reg;
    logic [31:0]           ne_reg, ne_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [RING_DEPTH-1:0] valid_reg, valid_next;
    logic                  aborted_reg, aborted_next;

    logic [1:0]            q_type_reg;
    logic [31:0]           q_idx_reg;
    logic [STORE_W-1:0]    q_pay_reg;
    logic                  q_ok_reg;

    logic [STORE_W:0]      mem [RING_DEPTH];
    logic [STORE_W:0]      rd_data_reg;
    logic [PTR_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [PTR_W-1:0]      slot;

    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            status_reg, status_next;
    logic [31:0]           out_index_reg, out_index_next;
    logic [31:0]           out_payload_reg, out_payload_next;
    logic                  out_ok_reg, out_ok_next;
    logic                  all_done_reg, all_done_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  accept;
    logic                  cfg_write;
    logic [WIN_W-1:0]      eff_win;
    logic [32:0]           win_end;
    logic                  below_end;
    logic                  in_window;
    logic [31:0]           diff;
    logic [PTR_W:0]        slot_sum;
    logic [PTR_W-1:0]      head_inc;
    logic [31:0]           ne_inc;
    logic                  more_after_store;
    logic                  more_after_deliver;
    logic                  emit_deliver;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == wrb_pkg::ADDR_WINDOW_SIZE)
                       ? {25'd0, window_size_reg} : total_frames_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_index   = out_index_reg;
    assign out_payload = out_payload_reg;
    assign out_ok      = out_ok_reg;
    assign all_done    = all_done_reg;
    assign last        = last_reg;

    always_comb
    begin
        if (window_size_reg == 7'd0)
        begin
            eff_win = WIN_W'(1);
        end
        else if (window_size_reg > 7'(RING_DEPTH))
        begin
            eff_win = WIN_W'(RING_DEPTH);
        end
        else
        begin
            eff_win = window_size_reg[WIN_W-1:0];
        end
    end

    assign win_end   = {1'b0, ne_reg} + 33'(eff_win);
    assign below_end = {1'b0, q_idx_reg} < win_end;
    assign in_window = (q_idx_reg >= ne_reg) && below_end && (q_idx_reg < total_frames_reg);

    assign diff     = q_idx_reg - ne_reg;
    assign slot_sum = {1'b0, head_reg} + {1'b0, diff[PTR_W-1:0]};
    assign slot     = (slot_sum >= (PTR_W+1)'(RING_DEPTH))
                      ? PTR_W'(slot_sum - (PTR_W+1)'(RING_DEPTH)) : slot_sum[PTR_W-1:0];

    assign head_inc = (head_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ne_inc   = ne_reg + 32'd1;

    assign more_after_store   = (ne_reg < total_frames_reg)
                                && (valid_reg[head_reg] || (slot == head_reg));
    assign more_after_deliver = (ne_inc < total_frames_reg) && valid_reg[head_inc]
                                && (head_inc != head_reg);

    assign emit_deliver = (state_reg == S_DELIVER) && out_free;
    assign rd_addr      = emit_deliver ? head_inc : head_reg;

    always_comb
    begin
        state_next       = state_reg;
        ne_next          = ne_reg;
        head_next        = head_reg;
        valid_next       = valid_reg;
        aborted_next     = aborted_reg;
        mem_we           = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        out_index_next   = out_index_reg;
        out_payload_next = out_payload_reg;
        out_ok_next      = out_ok_reg;
        all_done_next    = all_done_reg;
        last_next        = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (q_type_reg != wrb_pkg::REQ_ADMIT && q_type_reg != wrb_pkg::REQ_COMPLETE
                    && q_type_reg != wrb_pkg::REQ_ABORT)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_index_next   = q_idx_reg;
                    out_payload_next = 32'd0;
                    out_ok_next      = 1'b0;
                    all_done_next    = ne_reg >= total_frames_reg;
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                    case (q_type_reg)
                        wrb_pkg::REQ_ADMIT:
                        begin
                            if (aborted_reg)
                            begin
                                status_next = wrb_pkg::ST_REFUSED;
                            end
                            else if (below_end)
                            begin
                                status_next = wrb_pkg::ST_GRANT;
                            end
                            else
                            begin
                                status_next = wrb_pkg::ST_WAIT;
                            end
                        end
                        wrb_pkg::REQ_COMPLETE:
                        begin
                            if (aborted_reg)
                            begin
                                status_next = wrb_pkg::ST_PUSH_ABORTED;
                            end
                            else if (!in_window)
                            begin
                                status_next = wrb_pkg::ST_OUT_OF_WINDOW;
                            end
                            else if (valid_reg[slot])
                            begin
                                status_next = wrb_pkg::ST_DUPLICATE;
                            end
                            else
                            begin
                                status_next       = wrb_pkg::ST_STORED;
                                mem_we            = 1'b1;
                                valid_next[slot]  = 1'b1;
                                last_next         = !more_after_store;
                                state_next        = more_after_store ? S_READ : S_IDLE;
                            end
                        end
                        default:
                        begin
                            status_next    = wrb_pkg::ST_ABORT_DONE;
                            out_index_next = 32'd0;
                            aborted_next   = 1'b1;
                            valid_next     = '0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = wrb_pkg::ST_DELIVERED;
                    out_index_next   = ne_reg;
                    out_payload_next = 32'(rd_data_reg[STORE_W-1:0]);
                    out_ok_next      = rd_data_reg[STORE_W];
                    all_done_next    = ne_inc >= total_frames_reg;
                    last_next        = !more_after_deliver;
                    valid_next[head_reg] = 1'b0;
                    ne_next          = ne_inc;
                    head_next        = head_inc;
                    state_next       = more_after_deliver ? S_DELIVER : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            total_frames_reg <= 32'd0;
            window_size_reg  <= 7'd8;
            ne_reg           <= 32'd0;
            head_reg         <= '0;
            valid_reg        <= '0;
            aborted_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            head_reg      <= head_next;
            valid_reg     <= valid_next;
            aborted_reg   <= aborted_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (paddr[2])
                    wrb_pkg::ADDR_TOTAL_FRAMES: total_frames_reg <= pwdata;
                    wrb_pkg::ADDR_WINDOW_SIZE:  window_size_reg  <= pwdata[6:0];
                    default:                    total_frames_reg <= total_frames_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_type_reg <= req_type;
            q_idx_reg  <= item_index;
            q_pay_reg  <= payload[STORE_W-1:0];
            q_ok_reg   <= item_ok;
        end
        status_reg      <= status_next;
        out_index_reg   <= out_index_next;
        out_payload_reg <= out_payload_next;
        out_ok_reg      <= out_ok_next;
        all_done_reg    <= all_done_next;
        last_reg        <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot] <= {q_ok_reg, q_pay_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

    `WRB_ASSERT_ALWAYS(a_head_in_ring, head_reg <= PTR_W'(RING_DEPTH - 1))
    `WRB_ASSERT_IMPLY(a_deliver_valid, emit_deliver, valid_reg[head_reg])
    `WRB_ASSERT_ALWAYS(a_aborted_empty, !aborted_reg || valid_reg == '0)
    `WRB_ASSERT_NEXT(a_deliver_advances, emit_deliver, ne_reg == $past(ne_reg) + 32'd1)

endmodule

// File: bench/windowed_reorder_buffer_tb.sv
`timescale 1ns / 100ps

module windowed_reorder_buffer_tb;

    localparam int RING = wrb_pkg::RING_DEPTH_DEF;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 60;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] index;
        logic [31:0] data;
        logic        ok;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] index;
        logic [31:0] data;
        logic        ok;
        logic        done;
        logic        last;
    } resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        in_valid = 1'b0;
    wire         in_stall;
    logic [1:0]  req_type = '0;
    logic [31:0] item_index = '0;
    logic [31:0] payload = '0;
    logic        item_ok = 1'b0;
    wire         out_valid;
    logic        out_stall = 1'b0;
    wire  [3:0]  status;
    wire  [31:0] out_index;
    wire  [31:0] out_payload;
    wire         out_ok;
    wire         all_done;
    wire         last;

    windowed_reorder_buffer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .item_index  (item_index),
        .payload     (payload),
        .item_ok     (item_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_index   (out_index),
        .out_payload (out_payload),
        .out_ok      (out_ok),
        .all_done    (all_done),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [31:0]     run_length;
    logic [6:0]      window_reg;
    logic [RING-1:0] slot_full;
    logic [31:0]     slot_data [RING];
    logic            slot_good [RING];
    logic [31:0]     next_exp;
    logic            aborted;

    req_t        pending_reqs [$];
    resp_t       awaited_results [$];
    req_t        offered;
    int unsigned queued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned fail_cnt = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned results_taken = 0;
    int unsigned hold_left = 0;
    bit          held = 1'b0;
    int unsigned mode_left = 0;
    int unsigned stall_pct = 0;
    int unsigned idle_cycles = 0;

    function automatic int unsigned open_window();
        if (window_reg == 0)
            return 1;
        if (window_reg > RING)
            return RING;
        return window_reg;
    endfunction

    function automatic resp_t make_resp(logic [3:0] st, logic [31:0] idx, logic [31:0] data,
                                        logic ok);
        resp_t r;
        r.status = st;
        r.index = idx;
        r.data = data;
        r.ok = ok;
        r.done = (next_exp >= run_length);
        r.last = 1'b0;
        return r;
    endfunction

    task automatic reassemble_step(input req_t r);
        resp_t       batch [$];
        resp_t       res;
        logic [32:0] wend;
        int unsigned s;
        int unsigned h;
        wend = {1'b0, next_exp} + 33'(open_window());
        s = r.index % RING;
        case (r.kind)
            wrb_pkg::REQ_ADMIT:
            begin
                if (aborted)
                    res = make_resp(wrb_pkg::ST_REFUSED, r.index, '0, 1'b0);
                else if ({1'b0, r.index} < wend)
                    res = make_resp(wrb_pkg::ST_GRANT, r.index, '0, 1'b0);
                else
                    res = make_resp(wrb_pkg::ST_WAIT, r.index, '0, 1'b0);
                batch.insert(batch.size(), res);
            end
            wrb_pkg::REQ_COMPLETE:
            begin
                if (aborted)
                    batch.insert(batch.size(),
                                 make_resp(wrb_pkg::ST_PUSH_ABORTED, r.index, '0, 1'b0));
                else if (r.index < next_exp || {1'b0, r.index} >= wend
                         || r.index >= run_length)
                    batch.insert(batch.size(),
                                 make_resp(wrb_pkg::ST_OUT_OF_WINDOW, r.index, '0, 1'b0));
                else if (slot_full[s])
                    batch.insert(batch.size(),
                                 make_resp(wrb_pkg::ST_DUPLICATE, r.index, '0, 1'b0));
                else
                begin
                    slot_full[s] = 1'b1;
                    slot_data[s] = r.data;
                    slot_good[s] = r.ok;
                    batch.insert(batch.size(),
                                 make_resp(wrb_pkg::ST_STORED, r.index, '0, 1'b0));
                    while (batch.size() < RING + 1 && next_exp < run_length
                           && slot_full[next_exp % RING])
                    begin
                        h = next_exp % RING;
                        slot_full[h] = 1'b0;
                        next_exp = next_exp + 1;
                        res = make_resp(wrb_pkg::ST_DELIVERED, next_exp - 1, slot_data[h],
                                        slot_good[h]);
                        batch.insert(batch.size(), res);
                    end
                end
            end
            wrb_pkg::REQ_ABORT:
            begin
                aborted = 1'b1;
                slot_full = '0;
                batch.insert(batch.size(), make_resp(wrb_pkg::ST_ABORT_DONE, '0, '0, 1'b0));
            end
            default:
            begin
            end
        endcase
        if (batch.size() != 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                awaited_results.insert(awaited_results.size(), batch[i]);
        end
    endtask

    task automatic queue_req(input logic [1:0] kind, input logic [31:0] idx,
                             input logic [31:0] data, input logic ok);
        req_t r;
        r.kind = kind;
        r.index = idx;
        r.data = data;
        r.ok = ok;
        pending_reqs.insert(pending_reqs.size(), r);
        queued_cnt++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (accepted_cnt != queued_cnt || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == wrb_pkg::ADDR_TOTAL_FRAMES)
            run_length = value;
        else
            window_reg = value[6:0];
    endtask

    // Each round completes one full window in shuffled order, mixed with admissions and with
    // completions that are duplicated, behind, ahead or random, and with unknown request types.
    task automatic random_phase(input int unsigned quota);
        int unsigned base;
        int unsigned w;
        int unsigned made;
        int unsigned j;
        int unsigned k;
        int unsigned tmp;
        int unsigned pick;
        int unsigned order [RING];
        base = next_exp;
        w = open_window();
        made = 0;
        while (made < quota)
        begin
            for (j = 0; j < w; j++)
                order[j] = base + j;
            for (j = w - 1; j > 0; j--)
            begin
                k = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[k];
                order[k] = tmp;
            end
            for (j = 0; j < w; j++)
            begin
                pick = $urandom_range(0, 11);
                case (pick)
                    0: queue_req(wrb_pkg::REQ_ADMIT, base + w + $urandom_range(0, 3),
                                 $urandom(), 1'($urandom_range(0, 1)));
                    1: queue_req(wrb_pkg::REQ_COMPLETE, order[$urandom_range(0, j)],
                                 $urandom(), 1'($urandom_range(0, 1)));
                    2: queue_req(wrb_pkg::REQ_COMPLETE, base - 1 - $urandom_range(0, 2),
                                 $urandom(), 1'($urandom_range(0, 1)));
                    3: queue_req(wrb_pkg::REQ_COMPLETE, base + w + $urandom_range(0, 3),
                                 $urandom(), 1'($urandom_range(0, 1)));
                    4: queue_req(2'($urandom_range(0, 1)), $urandom(), $urandom(),
                                 1'($urandom_range(0, 1)));
                    5: queue_req(REQ_UNKNOWN, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
                    6, 7, 8: queue_req(wrb_pkg::REQ_ADMIT, order[j], $urandom(),
                                       1'($urandom_range(0, 1)));
                    default:
                    begin
                    end
                endcase
                if (pick <= 4 || (pick >= 6 && pick <= 8))
                    made++;
                queue_req(wrb_pkg::REQ_COMPLETE, order[j], $urandom(),
                          1'($urandom_range(0, 1)));
                made++;
            end
            base = base + w;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                reassemble_step(offered);
                accepted_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0 || pending_reqs.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    offered = pending_reqs.pop_front();
                    req_type <= offered.kind;
                    item_index <= offered.index;
                    payload <= offered.data;
                    item_ok <= offered.ok;
                    in_valid <= 1'b1;
                    if (burst_left != 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // After a number of results the receiver holds off once, so that the input backs up behind the held result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                results_taken++;
            if (!held && results_taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 90);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 65;
                    endcase
                end
                mode_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        resp_t got;
        resp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, out_index, out_payload, out_ok, all_done, last};
            if (awaited_results.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected: status %0d index %h payload %h ok %b done %b last %b",
                             got.status, got.index, got.data, got.ok, got.done, got.last);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display("mismatch: expected status %0d index %h payload %h ok %b %s",
                                 want.status, want.index, want.data, want.ok,
                                 $sformatf("done %b last %b", want.done, want.last));
                        $display("          got      status %0d index %h payload %h ok %b %s",
                                 got.status, got.index, got.data, got.ok,
                                 $sformatf("done %b last %b", got.done, got.last));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        run_length = '0;
        window_reg = 7'd8;
        slot_full = '0;
        foreach (slot_data[i])
        begin
            slot_data[i] = '0;
            slot_good[i] = 1'b0;
        end
        next_exp = '0;
        aborted = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Empty run with the default window.
        queue_req(wrb_pkg::REQ_ADMIT, 32'd0, 32'hFFFF_FFFF, 1'b1);
        queue_req(wrb_pkg::REQ_ADMIT, 32'd7, 32'd0, 1'b0);
        queue_req(wrb_pkg::REQ_ADMIT, 32'd8, 32'd0, 1'b0);
        queue_req(wrb_pkg::REQ_ADMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd0, 32'hFFFF_FFFF, 1'b1);
        queue_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // A zero window is clamped to one.
        write_reg(wrb_pkg::ADDR_TOTAL_FRAMES, 32'd20);
        write_reg(wrb_pkg::ADDR_WINDOW_SIZE, 32'd0);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd0, 32'hFFFF_FFFF, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd2, 32'd0, 1'b0);
        queue_req(wrb_pkg::REQ_ADMIT, 32'd1, 32'd0, 1'b0);
        queue_req(wrb_pkg::REQ_ADMIT, 32'd2, 32'd0, 1'b0);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd1, 32'd0, 1'b0);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd1, 32'h1234_5678, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd2, 32'hA5A5_5A5A, 1'b1);
        wait_idle();

        // An oversized window is clamped to the ring depth; one completion drains it all.
        write_reg(wrb_pkg::ADDR_WINDOW_SIZE, 32'd127);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd4, 32'h0000_0004, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd4, 32'hDEAD_BEEF, 1'b0);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd11, 32'h0000_000B, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd10, 32'h0000_000A, 1'b0);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd5, 32'h0000_0005, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd6, 32'h0000_0006, 1'b0);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd7, 32'h0000_0007, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd8, 32'h0000_0008, 1'b0);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd9, 32'h0000_0009, 1'b1);
        queue_req(wrb_pkg::REQ_COMPLETE, 32'd3, 32'h0000_0003, 1'b1);
        wait_idle();

        write_reg(wrb_pkg::ADDR_TOTAL_FRAMES, 32'hFFFF_FFFF);
        random_phase(20);
        wait_idle();
        random_phase(20);
        wait_idle();
        write_reg(wrb_pkg::ADDR_WINDOW_SIZE, 32'd3);
        random_phase(15);
        wait_idle();
        write_reg(wrb_pkg::ADDR_WINDOW_SIZE, 32'd64);
        random_phase(20);
        wait_idle();
        write_reg(wrb_pkg::ADDR_WINDOW_SIZE, 32'd1);
        random_phase(8);
        wait_idle();

        // The run ends inside the next window.
        write_reg(wrb_pkg::ADDR_TOTAL_FRAMES, next_exp + 32'd5);
        write_reg(wrb_pkg::ADDR_WINDOW_SIZE, 32'd8);
        random_phase(10);
        wait_idle();

        queue_req(wrb_pkg::REQ_ABORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_req(wrb_pkg::REQ_ADMIT, next_exp, 32'd0, 1'b0);
        queue_req(wrb_pkg::REQ_COMPLETE, next_exp, 32'h5555_AAAA, 1'b1);
        queue_req(wrb_pkg::REQ_ABORT, 32'd0, 32'd0, 1'b0);
        repeat (10)
            queue_req(2'($urandom_range(0, 3)), next_exp + $urandom_range(0, 9), $urandom(),
                      1'($urandom_range(0, 1)));
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
